>>> hdl/ohlcv_pkg.sv
// Shared types, constants and calendar helpers of the OHLCV bar aggregator.
`default_nettype none

package ohlcv_pkg;

  // Field widths
  localparam int PRICE_W   = 32;
  localparam int VOL_IN_W  = 40;
  localparam int VOL_ACC_W = 48;

  // Request queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Calendar constants
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned LAST_YEAR    = 2099;
  // ceil(2^19 / 7): exact quotient by seven for values below 2^16
  localparam int unsigned RECIP7       = 74899;
  localparam int unsigned RECIP7_SHIFT = 19;

  // Bar length codes
  localparam logic [3:0] LEN_1M    = 4'd0;
  localparam logic [3:0] LEN_5M    = 4'd1;
  localparam logic [3:0] LEN_10M   = 4'd2;
  localparam logic [3:0] LEN_15M   = 4'd3;
  localparam logic [3:0] LEN_30M   = 4'd4;
  localparam logic [3:0] LEN_60M   = 4'd5;
  localparam logic [3:0] LEN_DAY   = 4'd6;
  localparam logic [3:0] LEN_WEEK  = 4'd7;
  localparam logic [3:0] LEN_MONTH = 4'd8;

  // Calendar timestamp plus OHLCV of one bar
  typedef struct packed {
    logic [11:0]          year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
    logic [PRICE_W-1:0]   open;
    logic [PRICE_W-1:0]   high;
    logic [PRICE_W-1:0]   low;
    logic [PRICE_W-1:0]   close;
    logic [VOL_ACC_W-1:0] volume;
  } bar_t;

  // One classified request as it sits in the queue
  typedef struct packed {
    logic                flush;
    logic [31:0]         start;
    logic [11:0]         year;
    logic [3:0]          month;
    logic [4:0]          day;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [PRICE_W-1:0]  open;
    logic [PRICE_W-1:0]  high;
    logic [PRICE_W-1:0]  low;
    logic [PRICE_W-1:0]  close;
    logic [VOL_IN_W-1:0] volume;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t data;
  } q_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

  // Days in a month; February follows the leap flag
  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    unique case (mo)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  // Days of a common year before the first of the month
  function automatic logic [8:0] month_cum(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Floor a minute to the bar grid of a minute-based length
  function automatic logic [5:0] minute_floor(input logic [5:0] mi, input logic [3:0] len);
    logic [5:0] r;
    r = '0;
    unique case (len)
      LEN_1M: r = mi;
      LEN_5M: begin
        for (int k = 0; k < 60; k += 5) if (mi >= 6'(k)) r = 6'(k);
      end
      LEN_10M: begin
        for (int k = 0; k < 60; k += 10) if (mi >= 6'(k)) r = 6'(k);
      end
      LEN_15M: begin
        for (int k = 0; k < 60; k += 15) if (mi >= 6'(k)) r = 6'(k);
      end
      LEN_30M: r = (mi >= 6'd30) ? 6'd30 : 6'd0;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ohlcv_front.sv
// Front end: accepts requests, checks dates and computes bucket starts.
`default_nettype none

module ohlcv_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [3:0]                   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_action,
  input  wire logic [11:0]                  in_year,
  input  wire logic [3:0]                   in_month,
  input  wire logic [4:0]                   in_day,
  input  wire logic [4:0]                   in_hour,
  input  wire logic [5:0]                   in_minute,
  input  wire logic [5:0]                   in_second,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]  in_open_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]  in_high_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]  in_low_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]  in_close_price,
  input  wire logic [ohlcv_pkg::VOL_IN_W-1:0] in_volume,
  input  wire ohlcv_pkg::q_stat_t           q_stat,
  output ohlcv_pkg::q_push_t                q_push
);
  import ohlcv_pkg::*;

  logic [3:0]  bar_length_r;
  logic        accept;
  logic        leap;
  logic        date_ok;
  logic        keep;
  logic [6:0]  yoff;
  logic [15:0] days;
  logic [16:0] todf;
  logic [4:0]  dm1;
  logic [QCNT_W:0] pending;

  logic        v1_r;
  q_entry_t    ent1_r;
  logic [15:0] days1_r;
  logic [16:0] todf1_r;
  logic [4:0]  dm1_r;
  logic [3:0]  len1_r;

  logic        v2_r;
  q_entry_t    ent2_r;
  logic [31:0] daysec2_r;
  logic [15:0] x2_r;
  logic [12:0] q2_r;
  logic [21:0] dmsec2_r;
  logic [16:0] todf2_r;
  logic [3:0]  len2_r;

  logic [32:0] q7_prod;
  logic [2:0]  off;
  logic [31:0] start;

  // Hold the bar length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_length_r <= LEN_DAY;
    end else if (cfg_we) begin
      bar_length_r <= cfg_wdata;
    end
  end

  // Stall while the queue could not take every request in flight plus one more
  assign pending  = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(v1_r) + (QCNT_W + 1)'(v2_r);
  assign in_stall = pending >= (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;

  // Classify the request: drop bad dates and lengths without meaning
  assign leap    = (in_year[1:0] == 2'd0);
  assign date_ok = (in_year >= 12'(EPOCH_YEAR)) && (in_year <= 12'(LAST_YEAR)) &&
                   (in_month >= 4'd1) && (in_month <= 4'd12) &&
                   (in_day >= 5'd1) && (in_day <= month_days(in_month, leap)) &&
                   (in_hour <= 5'd23) && (in_minute <= 6'd59) && (in_second <= 6'd59);
  assign keep    = in_action || (date_ok && (bar_length_r <= LEN_MONTH));

  // Count days since the epoch; leap years in range are every fourth year
  assign yoff = 7'(in_year - 12'(EPOCH_YEAR));
  assign dm1  = in_day - 5'd1;
  assign days = 16'(yoff) * 16'd365 + 16'((8'(yoff) + 8'd1) >> 2) +
                16'(month_cum(in_month)) + 16'(leap && (in_month > 4'd2)) + 16'(dm1);
  assign todf = 17'(in_hour) * 17'd3600 +
                17'(minute_floor(in_minute, bar_length_r)) * 17'd60;

  // Stage 1 and stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept && keep;
      v2_r <= v1_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    ent1_r.flush  <= in_action;
    ent1_r.start  <= '0;
    ent1_r.year   <= in_year;
    ent1_r.month  <= in_month;
    ent1_r.day    <= in_day;
    ent1_r.hour   <= in_hour;
    ent1_r.minute <= in_minute;
    ent1_r.second <= in_second;
    ent1_r.open   <= in_open_price;
    ent1_r.high   <= in_high_price;
    ent1_r.low    <= in_low_price;
    ent1_r.close  <= in_close_price;
    ent1_r.volume <= in_volume;
    days1_r       <= days;
    todf1_r       <= todf;
    dm1_r         <= dm1;
    len1_r        <= bar_length_r;
  end

  // Stage 2: scale days to seconds and divide by seven for the weekday
  assign q7_prod = 33'(days1_r + 16'd3) * 33'(RECIP7);

  always_ff @(posedge clk) begin
    ent2_r    <= ent1_r;
    daysec2_r <= 32'(days1_r) * 32'(SECS_PER_DAY);
    x2_r      <= days1_r + 16'd3;
    q2_r      <= 13'(q7_prod >> RECIP7_SHIFT);
    dmsec2_r  <= 22'(dm1_r) * 22'(SECS_PER_DAY);
    todf2_r   <= todf1_r;
    len2_r    <= len1_r;
  end

  // Stage 3: pick the bucket start; the first week wraps below zero
  assign off = 3'(x2_r - 16'(q2_r) * 16'd7);

  always_comb begin
    priority if (len2_r <= LEN_60M) begin
      start = daysec2_r + 32'(todf2_r);
    end else if (len2_r == LEN_DAY) begin
      start = daysec2_r;
    end else if (len2_r == LEN_WEEK) begin
      start = daysec2_r - 32'(off) * 32'(SECS_PER_DAY);
    end else begin
      start = daysec2_r - 32'(dmsec2_r);
    end
  end

  always_comb begin
    q_push.valid      = v2_r;
    q_push.data       = ent2_r;
    q_push.data.start = start;
  end

endmodule

`default_nettype wire

>>> hdl/ohlcv_queue.sv
// Request queue that decouples the front end from the bar merge stage.
`default_nettype none

module ohlcv_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ohlcv_pkg::q_push_t  q_push,
  input  wire logic                pop,
  output ohlcv_pkg::q_entry_t      head,
  output ohlcv_pkg::q_stat_t       q_stat
);
  import ohlcv_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  // Advance pointers and track the fill level
  always_comb begin
    count_nxt = count_r;
    if (q_push.valid && !pop) count_nxt = count_r + QCNT_W'(1);
    if (!q_push.valid && pop) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.valid) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)          rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (q_push.valid) mem_r[wr_ptr_r] <= q_push.data;
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));

  // Front end credit keeps pushes off a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> (count_r < QCNT_W'(QDEPTH)) || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> hdl/ohlcv_back.sv
// Back end: merges requests into the open bar and registers finished bars.
`default_nettype none

module ohlcv_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ohlcv_pkg::q_entry_t            head,
  input  wire ohlcv_pkg::q_stat_t             q_stat,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [11:0]                         out_bar_year,
  output logic [3:0]                          out_bar_month,
  output logic [4:0]                          out_bar_day,
  output logic [4:0]                          out_bar_hour,
  output logic [5:0]                          out_bar_minute,
  output logic [5:0]                          out_bar_second,
  output logic [ohlcv_pkg::PRICE_W-1:0]       out_bar_open,
  output logic [ohlcv_pkg::PRICE_W-1:0]       out_bar_high,
  output logic [ohlcv_pkg::PRICE_W-1:0]       out_bar_low,
  output logic [ohlcv_pkg::PRICE_W-1:0]       out_bar_close,
  output logic [ohlcv_pkg::VOL_ACC_W-1:0]     out_bar_volume
);
  import ohlcv_pkg::*;

  logic        active_r, active_nxt;
  logic [31:0] bucket_r, bucket_nxt;
  bar_t        acc_r, acc_nxt;
  bar_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        emit;
  logic        match;
  logic [VOL_ACC_W:0] vsum;

  // Pop whenever the queue holds a request and the result register is free or being taken
  assign pop   = !q_stat.empty && (!out_valid_r || !out_stall);
  assign match = active_r && (head.start == bucket_r);
  assign vsum  = (VOL_ACC_W + 1)'(acc_r.volume) + (VOL_ACC_W + 1)'(head.volume);

  // Merge, open or close the bar
  always_comb begin
    active_nxt = active_r;
    bucket_nxt = bucket_r;
    acc_nxt    = acc_r;
    emit       = 1'b0;
    if (pop) begin
      priority if (head.flush) begin
        emit       = active_r;
        active_nxt = 1'b0;
      end else if (match) begin
        if (head.high > acc_r.high) acc_nxt.high = head.high;
        if (head.low < acc_r.low)   acc_nxt.low  = head.low;
        acc_nxt.close  = head.close;
        acc_nxt.volume = vsum[VOL_ACC_W] ? {VOL_ACC_W{1'b1}} : vsum[VOL_ACC_W-1:0];
        acc_nxt.year   = head.year;
        acc_nxt.month  = head.month;
        acc_nxt.day    = head.day;
        acc_nxt.hour   = head.hour;
        acc_nxt.minute = head.minute;
        acc_nxt.second = head.second;
      end else begin
        emit           = active_r;
        active_nxt     = 1'b1;
        bucket_nxt     = head.start;
        acc_nxt.open   = head.open;
        acc_nxt.high   = head.high;
        acc_nxt.low    = head.low;
        acc_nxt.close  = head.close;
        acc_nxt.volume = VOL_ACC_W'(head.volume);
        acc_nxt.year   = head.year;
        acc_nxt.month  = head.month;
        acc_nxt.day    = head.day;
        acc_nxt.hour   = head.hour;
        acc_nxt.minute = head.minute;
        acc_nxt.second = head.second;
      end
    end
  end

  // Load the result register with the finished bar
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bucket_r <= bucket_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bar_year   = out_r.year;
  assign out_bar_month  = out_r.month;
  assign out_bar_day    = out_r.day;
  assign out_bar_hour   = out_r.hour;
  assign out_bar_minute = out_r.minute;
  assign out_bar_second = out_r.second;
  assign out_bar_open   = out_r.open;
  assign out_bar_high   = out_r.high;
  assign out_bar_low    = out_r.low;
  assign out_bar_close  = out_r.close;
  assign out_bar_volume = out_r.volume;

  // A pending result is never overwritten
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(out_valid_r && out_stall))
    else $error("pop while result is blocked");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.flush |=> !active_r)
    else $error("bar still open after flush");

  a_record_opens: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head.flush |=> active_r && (bucket_r == $past(head.start)))
    else $error("record did not land in its bucket");

endmodule

`default_nettype wire

>>> hdl/ohlcv_bar_aggregator_core.sv
// Top level of the OHLCV bar aggregator.
//
// Input channel (in_*): one request per accepted cycle, either a price record
// or a flush. Records with an invalid date, or any record while bar_length
// holds a code above 8, are dropped. Result channel (out_*): one finished bar
// per accepted cycle. Both sides use valid/stall; a request or result moves
// at an edge where valid is high and stall is low.
// Configuration: cfg_we writes cfg_wdata into bar_length; write only while
// the block is idle.
// Throughput: one request per cycle, sustained while results are taken.
// A bar closed by a request reaches out_valid once that request has passed the
// first and second front stages, the queue write and the merge stage.
// Reset: empties the pipeline and queue, closes any open bar and sets
// bar_length to day bars.
// Stall: a blocked result holds in its register; the merge stage stops, the
// 8-entry queue fills and in_stall rises once every slot is spoken for.
`default_nettype none

module ohlcv_bar_aggregator_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [3:0]                       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_action,
  input  wire logic [11:0]                      in_year,
  input  wire logic [3:0]                       in_month,
  input  wire logic [4:0]                       in_day,
  input  wire logic [4:0]                       in_hour,
  input  wire logic [5:0]                       in_minute,
  input  wire logic [5:0]                       in_second,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]    in_open_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]    in_high_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]    in_low_price,
  input  wire logic [ohlcv_pkg::PRICE_W-1:0]    in_close_price,
  input  wire logic [ohlcv_pkg::VOL_IN_W-1:0]   in_volume,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [11:0]                           out_bar_year,
  output logic [3:0]                            out_bar_month,
  output logic [4:0]                            out_bar_day,
  output logic [4:0]                            out_bar_hour,
  output logic [5:0]                            out_bar_minute,
  output logic [5:0]                            out_bar_second,
  output logic [ohlcv_pkg::PRICE_W-1:0]         out_bar_open,
  output logic [ohlcv_pkg::PRICE_W-1:0]         out_bar_high,
  output logic [ohlcv_pkg::PRICE_W-1:0]         out_bar_low,
  output logic [ohlcv_pkg::PRICE_W-1:0]         out_bar_close,
  output logic [ohlcv_pkg::VOL_ACC_W-1:0]       out_bar_volume
);
  import ohlcv_pkg::*;

  q_push_t  q_push;
  q_stat_t  q_stat;
  q_entry_t head;
  logic     pop;

  // Classify requests and compute bucket starts
  ohlcv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_second      (in_second),
    .in_open_price  (in_open_price),
    .in_high_price  (in_high_price),
    .in_low_price   (in_low_price),
    .in_close_price (in_close_price),
    .in_volume      (in_volume),
    .q_stat         (q_stat),
    .q_push         (q_push)
  );

  // Buffer classified requests
  ohlcv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Merge into bars and deliver results
  ohlcv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bar_year   (out_bar_year),
    .out_bar_month  (out_bar_month),
    .out_bar_day    (out_bar_day),
    .out_bar_hour   (out_bar_hour),
    .out_bar_minute (out_bar_minute),
    .out_bar_second (out_bar_second),
    .out_bar_open   (out_bar_open),
    .out_bar_high   (out_bar_high),
    .out_bar_low    (out_bar_low),
    .out_bar_close  (out_bar_close),
    .out_bar_volume (out_bar_volume)
  );

endmodule

`default_nettype wire
